[src/tsfp_pkg.sv]
// ----------------------------------------------------------------------------
// tsfp_pkg: shared definitions for the typed serial frame parser
// Character codes, register indexes, reset values and the result word type.
// ----------------------------------------------------------------------------
`default_nettype none

package tsfp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 8;
  localparam int unsigned CfgIdxW = 1;

  localparam int unsigned MaxFrameLenDefault = 128;

  // Character codes
  localparam logic [ByteW-1:0] ChTab   = 8'h09;
  localparam logic [ByteW-1:0] ChNl    = 8'h0A;
  localparam logic [ByteW-1:0] ChCr    = 8'h0D;
  localparam logic [ByteW-1:0] ChShort = 8'h73;  // 's'
  localparam logic [ByteW-1:0] ChLong  = 8'h62;  // 'b'

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegShortLen = 1'd0;
  localparam logic [CfgIdxW-1:0] RegLongLen  = 1'd1;

  localparam logic [LenW-1:0] ShortLenReset = 8'd14;
  localparam logic [LenW-1:0] LongLenReset  = 8'd124;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             frame_kind;
    logic             last;
    logic             frame_good;
  } result_t;

endpackage

`default_nettype wire

[src/tsfp_if.sv]
// ----------------------------------------------------------------------------
// tsfp_if: channel interfaces of the typed serial frame parser
// Input byte channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsfp_in_if;
  logic                      valid;
  logic                      ready;
  logic [tsfp_pkg::ByteW-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface tsfp_out_if;
  logic                      valid;
  logic                      ready;
  logic [tsfp_pkg::ByteW-1:0] out_byte;
  logic                      frame_kind;
  logic                      last;
  logic                      frame_good;

  modport source (output valid, output out_byte, output frame_kind, output last,
                  output frame_good, input ready);
  modport sink   (input valid, input out_byte, input frame_kind, input last,
                  input frame_good, output ready);
endinterface

interface tsfp_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [tsfp_pkg::CfgIdxW-1:0] index;
  logic [tsfp_pkg::LenW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[src/typed_serial_frame_parser.sv]
// ----------------------------------------------------------------------------
// typed_serial_frame_parser: tab-delimited typed frame parser
// Turns a received byte stream into record words with kind and end marks.
// ----------------------------------------------------------------------------
// Output: a result word is registered, in the output or else the skid register.
// Throughput: one byte per cycle while the skid register is empty; the frame
//   state is updated in a single pass of compare and count logic, and an
//   output register plus a skid register keep the input open while one result waits downstream.
// Reset: rst_ni clears phase, count and kind and restores the length
//   registers to 14 (short) and 124 (long); no clearing pass.
`default_nettype none

module typed_serial_frame_parser #(
  parameter int unsigned MAX_FRAME_LEN = tsfp_pkg::MaxFrameLenDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  tsfp_in_if.sink          in_i,
  tsfp_out_if.source       out_o,
  tsfp_cfg_if.sink         cfg_i
);

  // Count holds 0 .. MAX_FRAME_LEN-1
  localparam int unsigned CntW = $clog2(MAX_FRAME_LEN);
  localparam logic [tsfp_pkg::LenW:0] LimMax = (tsfp_pkg::LenW+1)'(MAX_FRAME_LEN - 1);

  localparam logic [1:0] PhIdle   = 2'd0;
  localparam logic [1:0] PhFrame  = 2'd1;
  localparam logic [1:0] PhHeader = 2'd2;

  // --------------------------------------------------------------------------
  // Configuration registers; always ready
  // --------------------------------------------------------------------------
  logic [tsfp_pkg::LenW-1:0] short_len_q, long_len_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_len_q <= tsfp_pkg::ShortLenReset;
      long_len_q  <= tsfp_pkg::LongLenReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        tsfp_pkg::RegShortLen: short_len_q <= cfg_i.data;
        tsfp_pkg::RegLongLen:  long_len_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Frame state
  // --------------------------------------------------------------------------
  logic [1:0]      phase_q, phase_d;
  logic [CntW-1:0] count_q, count_d;
  logic            kind_q, kind_d;

  logic [1:0]                phase_eff;
  logic                      kind_eff;
  logic [tsfp_pkg::LenW-1:0] len_sel;
  logic [tsfp_pkg::LenW:0]   lim_w;
  logic [CntW-1:0]           lim;
  logic                      has_res;
  tsfp_pkg::result_t         res;
  logic [tsfp_pkg::ByteW-1:0] c;
  logic                      in_acc;

  assign c      = in_i.in_byte;
  assign in_acc = in_i.valid && in_i.ready;

  always_comb begin
    // Type byte resolves the header first; it is then a record byte too
    kind_eff  = kind_q;
    phase_eff = phase_q;
    if (phase_q == PhHeader) begin
      if (c == tsfp_pkg::ChShort) begin
        kind_eff  = 1'b0;
        phase_eff = PhFrame;
      end else if (c == tsfp_pkg::ChLong) begin
        kind_eff  = 1'b1;
        phase_eff = PhFrame;
      end else begin
        phase_eff = PhIdle;
      end
    end

    // limit = len - 1, floored at 0 and capped at MAX_FRAME_LEN - 1
    len_sel = kind_eff ? long_len_q : short_len_q;
    lim_w   = (len_sel == '0) ? '0 : {1'b0, len_sel} - 1'b1;
    if (lim_w > LimMax) lim_w = LimMax;
    lim = lim_w[CntW-1:0];

    phase_d = phase_eff;
    count_d = count_q;
    kind_d  = kind_eff;
    has_res = 1'b0;
    res.out_byte   = c;
    res.frame_kind = kind_eff;
    res.last       = 1'b0;
    res.frame_good = 1'b0;

    unique case (phase_eff)
      PhFrame: begin
        if (c == tsfp_pkg::ChNl) begin
          has_res        = 1'b1;
          res.last       = 1'b1;
          res.frame_good = (count_q == lim);
          count_d        = '0;
          phase_d        = PhIdle;
        end else if (c != tsfp_pkg::ChCr && c != tsfp_pkg::ChTab) begin
          // overlong records drop bytes and hold the count
          if (count_q < lim) begin
            has_res = 1'b1;
            count_d = count_q + 1'b1;
          end
        end
      end
      default: ;  // idle, or the unused code treated as idle
    endcase

    // a tab restarts the header anywhere, abandoning an open frame
    if (c == tsfp_pkg::ChTab) begin
      phase_d = PhHeader;
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      count_q <= '0;
      kind_q  <= 1'b0;
    end else if (in_acc) begin
      phase_q <= phase_d;
      count_q <= count_d;
      kind_q  <= kind_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output register with skid stage
  // --------------------------------------------------------------------------
  logic              out_valid_q, skid_valid_q;
  tsfp_pkg::result_t out_q, skid_q;
  logic              pop, push;

  assign in_i.ready = !skid_valid_q;
  assign pop  = out_valid_q && out_o.ready;
  assign push = in_acc && has_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) skid_valid_q <= 1'b0;
    end else if (push) begin
      if (out_valid_q && !pop) skid_valid_q <= 1'b1;
      else out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) out_q <= skid_q;
    end else if (push) begin
      if (out_valid_q && !pop) skid_q <= res;
      else out_q <= res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_byte   = out_q.out_byte;
  assign out_o.frame_kind = out_q.frame_kind;
  assign out_o.last       = out_q.last;
  assign out_o.frame_good = out_q.frame_good;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word held while output register empty");

  a_close_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && res.last) |=> (phase_q == PhIdle && count_q == '0))
    else $error("closing word did not return parser to idle");

  a_header_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhHeader) |-> (count_q == '0))
    else $error("byte count not cleared in header phase");

endmodule

`default_nettype wire
